@@ hw/rtl/vauk_pkg.sv @@
// ----------------------------------------------------------------------------
// vauk_pkg
// Types, constants and the lane microprogram of the leapfrog atom update core.
// ----------------------------------------------------------------------------
package vauk_pkg;

    localparam int DATA_W     = 32;
    localparam int KIN_W      = 48;
    localparam int MAG_W      = 62;
    localparam int ACC_W      = 96;
    localparam int PROD_W     = 64;
    localparam int MASS_W     = 24;
    localparam int INV_W      = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int STEP_W     = 5;
    localparam int NUM_LANES  = 3;
    localparam int LANE_IDX_W = 2;

    localparam logic [STEP_W-1:0]     LAST_STEP = STEP_W'(22);
    localparam logic [LANE_IDX_W-1:0] LAST_LANE = LANE_IDX_W'(NUM_LANES - 1);
    localparam logic [MAG_W-1:0]      MAG_CAP   = '1;
    localparam logic [KIN_W-1:0]      KIN_MAX   = '1;

    localparam logic [DATA_W-1:0] TIME_STEP_RST  = 32'd429497;
    localparam logic [DATA_W-1:0] FORCE_GAIN_RST = 32'd63234327;
    localparam logic [MASS_W-1:0] MASS_A_RST     = 24'd1048510;
    localparam logic [MASS_W-1:0] MASS_B_RST     = 24'd66050;
    localparam logic [INV_W-1:0]  INV_A_RST      = 17'd4096;
    localparam logic [INV_W-1:0]  INV_B_RST      = 17'd65026;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIME_STEP  = 3'd0,
        CFG_FORCE_GAIN = 3'd1,
        CFG_MASS_A     = 3'd2,
        CFG_MASS_B     = 3'd3,
        CFG_INV_A      = 3'd4,
        CFG_INV_B      = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [DATA_W-1:0] time_step;
        logic [DATA_W-1:0] force_gain;
        logic [MASS_W-1:0] mass_a;
        logic [MASS_W-1:0] mass_b;
        logic [INV_W-1:0]  inv_a;
        logic [INV_W-1:0]  inv_b;
    } cfg_t;

    typedef struct packed {
        logic [DATA_W-1:0] time_step;
        logic [DATA_W-1:0] force_gain;
        logic [MASS_W-1:0] mass;
        logic [INV_W-1:0]  inv_mass;
    } coef_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] force_x;
        logic signed [DATA_W-1:0] force_y;
        logic signed [DATA_W-1:0] force_z;
        logic signed [DATA_W-1:0] pos_x;
        logic signed [DATA_W-1:0] pos_y;
        logic signed [DATA_W-1:0] pos_z;
        logic signed [DATA_W-1:0] vel_x;
        logic signed [DATA_W-1:0] vel_y;
        logic signed [DATA_W-1:0] vel_z;
        logic                     atom_kind;
        logic                     last_atom;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] new_pos_x;
        logic signed [DATA_W-1:0] new_pos_y;
        logic signed [DATA_W-1:0] new_pos_z;
        logic signed [DATA_W-1:0] new_vel_x;
        logic signed [DATA_W-1:0] new_vel_y;
        logic signed [DATA_W-1:0] new_vel_z;
        logic [KIN_W-1:0]         kinetic_total;
        logic                     step_done;
    } out_item_t;

    typedef enum logic [3:0] {
        MA_FMAG,
        MA_G_LO,
        MA_G_HI,
        MA_A_LO,
        MA_A_HI,
        MA_VMAG,
        MA_SM_LO,
        MA_SM_HI,
        MA_SQ_LO,
        MA_SQ_HI
    } mul_a_sel_t;

    typedef enum logic [2:0] {
        MB_GAIN,
        MB_INV,
        MB_TS,
        MB_MASS,
        MB_SM_LO,
        MB_SM_HI
    } mul_b_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } acc_op_t;

    typedef enum logic [1:0] {
        SH_0,
        SH_32,
        SH_64
    } acc_sh_t;

    typedef enum logic [2:0] {
        FIN_NONE,
        FIN_G,
        FIN_A,
        FIN_DV,
        FIN_HV,
        FIN_DX,
        FIN_SQ,
        FIN_TERM
    } fin_dst_t;

    typedef enum logic [1:0] {
        AUX_NONE,
        AUX_VN,
        AUX_S,
        AUX_XN
    } aux_op_t;

    typedef struct packed {
        logic       mul_en;
        mul_a_sel_t a_sel;
        mul_b_sel_t b_sel;
        acc_op_t    acc_op;
        acc_sh_t    acc_sh;
        fin_dst_t   fin;
        aux_op_t    aux;
    } lane_cmd_t;

    typedef struct packed {
        logic                  load;
        lane_cmd_t             lane;
        logic                  kin_add;
        logic [LANE_IDX_W-1:0] kin_lane;
        logic                  publish;
    } dp_cmd_t;

    function automatic lane_cmd_t lane_nop();
        lane_cmd_t c;
        c.mul_en = 1'b0;
        c.a_sel  = MA_FMAG;
        c.b_sel  = MB_GAIN;
        c.acc_op = ACC_HOLD;
        c.acc_sh = SH_0;
        c.fin    = FIN_NONE;
        c.aux    = AUX_NONE;
        return c;
    endfunction

    // Each product is registered and accumulated in the next step.
    function automatic lane_cmd_t micro_cmd(input logic [STEP_W-1:0] step);
        lane_cmd_t c;
        c = lane_nop();
        case (step)
            5'd0:
            begin
                c.mul_en = 1'b1; c.a_sel = MA_FMAG; c.b_sel = MB_GAIN;
            end
            5'd1:
            begin
                c.acc_op = ACC_LOAD; c.acc_sh = SH_0;
            end
            5'd2:
            begin
                c.fin = FIN_G;
            end
            5'd3:
            begin
                c.mul_en = 1'b1; c.a_sel = MA_G_LO; c.b_sel = MB_INV;
            end
            5'd4:
            begin
                c.mul_en = 1'b1; c.a_sel = MA_G_HI; c.b_sel = MB_INV;
                c.acc_op = ACC_LOAD; c.acc_sh = SH_0;
            end
            5'd5:
            begin
                c.acc_op = ACC_ADD; c.acc_sh = SH_32;
            end
            5'd6:
            begin
                c.fin = FIN_A;
            end
            5'd7:
            begin
                c.mul_en = 1'b1; c.a_sel = MA_A_LO; c.b_sel = MB_TS;
            end
            5'd8:
            begin
                c.mul_en = 1'b1; c.a_sel = MA_A_HI; c.b_sel = MB_TS;
                c.acc_op = ACC_LOAD; c.acc_sh = SH_0;
            end
            5'd9:
            begin
                c.acc_op = ACC_ADD; c.acc_sh = SH_32;
            end
            5'd10:
            begin
                c.fin = FIN_DV;
            end
            5'd11:
            begin
                c.fin = FIN_HV; c.aux = AUX_VN;
            end
            5'd12:
            begin
                c.mul_en = 1'b1; c.a_sel = MA_VMAG; c.b_sel = MB_TS;
                c.aux = AUX_S;
            end
            5'd13:
            begin
                c.acc_op = ACC_LOAD; c.acc_sh = SH_0;
                c.mul_en = 1'b1; c.a_sel = MA_SM_LO; c.b_sel = MB_SM_LO;
            end
            5'd14:
            begin
                c.fin = FIN_DX;
                c.acc_op = ACC_LOAD; c.acc_sh = SH_0;
                c.mul_en = 1'b1; c.a_sel = MA_SM_LO; c.b_sel = MB_SM_HI;
            end
            5'd15:
            begin
                c.aux = AUX_XN;
                c.acc_op = ACC_ADD; c.acc_sh = SH_32;
                c.mul_en = 1'b1; c.a_sel = MA_SM_HI; c.b_sel = MB_SM_LO;
            end
            5'd16:
            begin
                c.acc_op = ACC_ADD; c.acc_sh = SH_32;
                c.mul_en = 1'b1; c.a_sel = MA_SM_HI; c.b_sel = MB_SM_HI;
            end
            5'd17:
            begin
                c.acc_op = ACC_ADD; c.acc_sh = SH_64;
            end
            5'd18:
            begin
                c.fin = FIN_SQ;
            end
            5'd19:
            begin
                c.mul_en = 1'b1; c.a_sel = MA_SQ_LO; c.b_sel = MB_MASS;
            end
            5'd20:
            begin
                c.mul_en = 1'b1; c.a_sel = MA_SQ_HI; c.b_sel = MB_MASS;
                c.acc_op = ACC_LOAD; c.acc_sh = SH_0;
            end
            5'd21:
            begin
                c.acc_op = ACC_ADD; c.acc_sh = SH_32;
            end
            5'd22:
            begin
                c.fin = FIN_TERM;
            end
            default:
            begin
                c = lane_nop();
            end
        endcase
        return c;
    endfunction

endpackage

@@ hw/rtl/vauk_if.sv @@
// ----------------------------------------------------------------------------
// vauk_if
// Valid/ready channels for atom items and update results.
// ----------------------------------------------------------------------------
interface vauk_in_if;
    logic                 valid;
    logic                 ready;
    vauk_pkg::in_item_t   data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface vauk_out_if;
    logic                 valid;
    logic                 ready;
    vauk_pkg::out_item_t  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/verlet_atom_update_kinetic_core.sv @@
// ----------------------------------------------------------------------------
// verlet_atom_update_kinetic_core
// Leapfrog update of one atom per item with a running kinetic energy sum.
// Each atom runs the 23-step microprogram on each axis lane's single 32x32
// multiplier, then the three axis terms fold into the 48-bit kinetic sum,
// the result register loads once the previous result is taken, and the core
// returns to idle. Only idle accepts an atom, so one atom is in flight.
// Reset: config and control registers take their defaults, kinetic sum clears,
// datapath registers are not reset, no clearing pass.
// ----------------------------------------------------------------------------
module verlet_atom_update_kinetic_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [vauk_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [vauk_pkg::DATA_W-1:0]       cfg_wdata,
    vauk_in_if.sink                           atom_in,
    vauk_out_if.source                        result_out
);

    vauk_pkg::cfg_t     cfg;
    vauk_pkg::dp_cmd_t  cmd;

    vauk_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    vauk_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (atom_in.valid),
        .in_ready  (atom_in.ready),
        .out_valid (result_out.valid),
        .out_ready (result_out.ready),
        .cmd       (cmd)
    );

    vauk_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .cfg      (cfg),
        .in_item  (atom_in.data),
        .out_item (result_out.data)
    );

endmodule

@@ hw/rtl/vauk_cfg.sv @@
// ----------------------------------------------------------------------------
// vauk_cfg
// Configuration register bank: time step, force gain, masses, inverse masses.
// ----------------------------------------------------------------------------
module vauk_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [vauk_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [vauk_pkg::DATA_W-1:0]        cfg_wdata,
    output vauk_pkg::cfg_t                     cfg
);

    vauk_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.time_step  <= vauk_pkg::TIME_STEP_RST;
            cfg_reg.force_gain <= vauk_pkg::FORCE_GAIN_RST;
            cfg_reg.mass_a     <= vauk_pkg::MASS_A_RST;
            cfg_reg.mass_b     <= vauk_pkg::MASS_B_RST;
            cfg_reg.inv_a      <= vauk_pkg::INV_A_RST;
            cfg_reg.inv_b      <= vauk_pkg::INV_B_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                vauk_pkg::CFG_TIME_STEP:  cfg_reg.time_step  <= cfg_wdata;
                vauk_pkg::CFG_FORCE_GAIN: cfg_reg.force_gain <= cfg_wdata;
                vauk_pkg::CFG_MASS_A:     cfg_reg.mass_a <= cfg_wdata[vauk_pkg::MASS_W-1:0];
                vauk_pkg::CFG_MASS_B:     cfg_reg.mass_b <= cfg_wdata[vauk_pkg::MASS_W-1:0];
                vauk_pkg::CFG_INV_A:      cfg_reg.inv_a  <= cfg_wdata[vauk_pkg::INV_W-1:0];
                vauk_pkg::CFG_INV_B:      cfg_reg.inv_b  <= cfg_wdata[vauk_pkg::INV_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ hw/rtl/vauk_lane.sv @@
// ----------------------------------------------------------------------------
// vauk_lane
// One axis: shared 32x32 multiplier, 96-bit partial product accumulator,
// round-and-saturate unit and the velocity, position and speed adders.
// ----------------------------------------------------------------------------
module vauk_lane (
    input  logic                                clk,
    input  logic                                load,
    input  logic signed [vauk_pkg::DATA_W-1:0]  force_in,
    input  logic signed [vauk_pkg::DATA_W-1:0]  pos_in,
    input  logic signed [vauk_pkg::DATA_W-1:0]  vel_in,
    input  vauk_pkg::coef_t                     coef,
    input  vauk_pkg::lane_cmd_t                 cmd,
    output logic signed [vauk_pkg::DATA_W-1:0]  new_pos,
    output logic signed [vauk_pkg::DATA_W-1:0]  new_vel,
    output logic [vauk_pkg::MAG_W-1:0]          term
);

    localparam int ACC_W = vauk_pkg::ACC_W;
    localparam int MAG_W = vauk_pkg::MAG_W;
    localparam int SUM_W = 50;

    logic [31:0]        fmag_reg;
    logic               fneg_reg;
    logic [31:0]        pos_reg;
    logic [31:0]        vel_reg;
    logic [63:0]        prod_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic [46:0]        g_reg;
    logic [47:0]        a_reg;
    logic [47:0]        dv_reg;
    logic [47:0]        hv_reg;
    logic [31:0]        dx_reg;
    logic [31:0]        vn_reg;
    logic [47:0]        sm_reg;
    logic [MAG_W-1:0]   sq_reg;
    logic [MAG_W-1:0]   term_reg;
    logic [31:0]        xn_reg;

    logic [31:0]        op_a;
    logic [31:0]        op_b;
    logic [63:0]        prod_next;
    logic [ACC_W-1:0]   pp_shifted;
    logic [5:0]         fin_sh;
    logic [ACC_W:0]     rnd_sum;
    logic [ACC_W:0]     fin_shifted;
    logic [MAG_W-1:0]   fin_val;
    logic [31:0]        vmag;
    logic [SUM_W-1:0]   dv_ext;
    logic [SUM_W-1:0]   hv_ext;
    logic [SUM_W-1:0]   dx_ext;
    logic [SUM_W-1:0]   vsum;
    logic [SUM_W-1:0]   ssum;
    logic [SUM_W-1:0]   smag;
    logic [SUM_W-1:0]   xsum;

    function automatic logic [31:0] sat32(input logic [SUM_W-1:0] v);
        if (!v[SUM_W-1] && (|v[SUM_W-2:31]))
            return 32'h7FFF_FFFF;
        else if (v[SUM_W-1] && !(&v[SUM_W-2:31]))
            return 32'h8000_0000;
        else
            return v[31:0];
    endfunction

    assign vmag = vn_reg[31] ? (~vn_reg + 32'd1) : vn_reg;

    always_comb
    begin
        case (cmd.a_sel)
            vauk_pkg::MA_FMAG:  op_a = fmag_reg;
            vauk_pkg::MA_G_LO:  op_a = g_reg[31:0];
            vauk_pkg::MA_G_HI:  op_a = {17'd0, g_reg[46:32]};
            vauk_pkg::MA_A_LO:  op_a = a_reg[31:0];
            vauk_pkg::MA_A_HI:  op_a = {16'd0, a_reg[47:32]};
            vauk_pkg::MA_VMAG:  op_a = vmag;
            vauk_pkg::MA_SM_LO: op_a = sm_reg[31:0];
            vauk_pkg::MA_SM_HI: op_a = {16'd0, sm_reg[47:32]};
            vauk_pkg::MA_SQ_LO: op_a = sq_reg[31:0];
            vauk_pkg::MA_SQ_HI: op_a = {2'd0, sq_reg[MAG_W-1:32]};
            default:            op_a = '0;
        endcase
        case (cmd.b_sel)
            vauk_pkg::MB_GAIN:  op_b = coef.force_gain;
            vauk_pkg::MB_INV:   op_b = {15'd0, coef.inv_mass};
            vauk_pkg::MB_TS:    op_b = coef.time_step;
            vauk_pkg::MB_MASS:  op_b = {8'd0, coef.mass};
            vauk_pkg::MB_SM_LO: op_b = sm_reg[31:0];
            vauk_pkg::MB_SM_HI: op_b = {16'd0, sm_reg[47:32]};
            default:            op_b = '0;
        endcase
    end

    assign prod_next = op_a * op_b;

    always_comb
    begin
        case (cmd.acc_sh)
            vauk_pkg::SH_0:  pp_shifted = {32'd0, prod_reg};
            vauk_pkg::SH_32: pp_shifted = {prod_reg, 32'd0};
            vauk_pkg::SH_64: pp_shifted = {prod_reg[31:0], 64'd0};
            default:         pp_shifted = '0;
        endcase
    end

    always_comb
    begin
        case (cmd.fin)
            vauk_pkg::FIN_DV: fin_sh = 6'd32;
            vauk_pkg::FIN_DX: fin_sh = 6'd32;
            vauk_pkg::FIN_HV: fin_sh = 6'd33;
            default:          fin_sh = 6'd16;
        endcase
    end

    assign rnd_sum     = {1'b0, acc_reg} + ((ACC_W+1)'(1) << (fin_sh - 6'd1));
    assign fin_shifted = rnd_sum >> fin_sh;
    assign fin_val     = (|fin_shifted[ACC_W:MAG_W]) ? vauk_pkg::MAG_CAP
                                                     : fin_shifted[MAG_W-1:0];

    assign dv_ext = {2'b00, dv_reg};
    assign hv_ext = {2'b00, hv_reg};
    assign dx_ext = {18'd0, dx_reg};
    assign vsum   = {{18{vel_reg[31]}}, vel_reg}
                  + (fneg_reg ? (~dv_ext + 50'd1) : dv_ext);
    assign ssum   = {{18{vn_reg[31]}}, vn_reg}
                  + (fneg_reg ? (~hv_ext + 50'd1) : hv_ext);
    assign smag   = ssum[SUM_W-1] ? (~ssum + 50'd1) : ssum;
    assign xsum   = {{18{pos_reg[31]}}, pos_reg}
                  + (vn_reg[31] ? (~dx_ext + 50'd1) : dx_ext);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            fmag_reg <= force_in[31] ? (~force_in + 32'd1) : force_in;
            fneg_reg <= force_in[31];
            pos_reg  <= pos_in;
            vel_reg  <= vel_in;
        end
        if (cmd.mul_en)
            prod_reg <= prod_next;
        case (cmd.acc_op)
            vauk_pkg::ACC_LOAD: acc_reg <= pp_shifted;
            vauk_pkg::ACC_ADD:  acc_reg <= acc_reg + pp_shifted;
            default: ;
        endcase
        case (cmd.fin)
            vauk_pkg::FIN_G:    g_reg    <= fin_val[46:0];
            vauk_pkg::FIN_A:    a_reg    <= fin_val[47:0];
            vauk_pkg::FIN_DV:   dv_reg   <= fin_val[47:0];
            vauk_pkg::FIN_HV:   hv_reg   <= fin_val[47:0];
            vauk_pkg::FIN_DX:   dx_reg   <= fin_val[31:0];
            vauk_pkg::FIN_SQ:   sq_reg   <= fin_val;
            vauk_pkg::FIN_TERM: term_reg <= fin_val;
            default: ;
        endcase
        case (cmd.aux)
            vauk_pkg::AUX_VN: vn_reg <= sat32(vsum);
            vauk_pkg::AUX_S:  sm_reg <= smag[47:0];
            vauk_pkg::AUX_XN: xn_reg <= sat32(xsum);
            default: ;
        endcase
    end

    assign new_pos = $signed(xn_reg);
    assign new_vel = $signed(vn_reg);
    assign term    = term_reg;

endmodule

@@ hw/rtl/vauk_dp.sv @@
// ----------------------------------------------------------------------------
// vauk_dp
// Datapath: three axis lanes, kinetic energy accumulator, result register.
// ----------------------------------------------------------------------------
module vauk_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  vauk_pkg::dp_cmd_t    cmd,
    input  vauk_pkg::cfg_t       cfg,
    input  vauk_pkg::in_item_t   in_item,
    output vauk_pkg::out_item_t  out_item
);

    localparam int NUM_LANES = vauk_pkg::NUM_LANES;
    localparam int KIN_W     = vauk_pkg::KIN_W;
    localparam int MAG_W     = vauk_pkg::MAG_W;
    localparam int DATA_W    = vauk_pkg::DATA_W;

    logic                      kind_reg;
    logic                      last_reg;
    logic [KIN_W-1:0]          ksum_reg;
    logic [KIN_W-1:0]          ksum_next;
    vauk_pkg::out_item_t       out_reg;
    vauk_pkg::coef_t           coef;

    logic signed [DATA_W-1:0]  force_arr [NUM_LANES];
    logic signed [DATA_W-1:0]  pos_arr   [NUM_LANES];
    logic signed [DATA_W-1:0]  vel_arr   [NUM_LANES];
    logic signed [DATA_W-1:0]  npos_arr  [NUM_LANES];
    logic signed [DATA_W-1:0]  nvel_arr  [NUM_LANES];
    logic [MAG_W-1:0]          term_arr  [NUM_LANES];
    logic [MAG_W-1:0]          term_sel;
    logic [MAG_W-1:0]          room;
    logic [KIN_W:0]            half_sum;

    assign force_arr[0] = in_item.force_x;
    assign force_arr[1] = in_item.force_y;
    assign force_arr[2] = in_item.force_z;
    assign pos_arr[0]   = in_item.pos_x;
    assign pos_arr[1]   = in_item.pos_y;
    assign pos_arr[2]   = in_item.pos_z;
    assign vel_arr[0]   = in_item.vel_x;
    assign vel_arr[1]   = in_item.vel_y;
    assign vel_arr[2]   = in_item.vel_z;

    assign coef.time_step  = cfg.time_step;
    assign coef.force_gain = cfg.force_gain;
    assign coef.mass       = kind_reg ? cfg.mass_b : cfg.mass_a;
    assign coef.inv_mass   = kind_reg ? cfg.inv_b : cfg.inv_a;

    for (genvar i = 0; i < NUM_LANES; i++)
    begin : lane_g
        vauk_lane u_lane (
            .clk      (clk),
            .load     (cmd.load),
            .force_in (force_arr[i]),
            .pos_in   (pos_arr[i]),
            .vel_in   (vel_arr[i]),
            .coef     (coef),
            .cmd      (cmd.lane),
            .new_pos  (npos_arr[i]),
            .new_vel  (nvel_arr[i]),
            .term     (term_arr[i])
        );
    end

    always_comb
    begin
        case (cmd.kin_lane)
            2'd0:    term_sel = term_arr[0];
            2'd1:    term_sel = term_arr[1];
            2'd2:    term_sel = term_arr[2];
            default: term_sel = '0;
        endcase
    end

    assign room     = MAG_W'(vauk_pkg::KIN_MAX - ksum_reg);
    assign half_sum = {1'b0, ksum_reg} + (KIN_W+1)'(1);

    always_comb
    begin
        ksum_next = ksum_reg;
        if (cmd.kin_add)
        begin
            if (term_sel >= room)
                ksum_next = vauk_pkg::KIN_MAX;
            else
                ksum_next = ksum_reg + term_sel[KIN_W-1:0];
        end
        else if (cmd.publish && last_reg)
        begin
            ksum_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ksum_reg <= '0;
        else
            ksum_reg <= ksum_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= in_item.atom_kind;
            last_reg <= in_item.last_atom;
        end
        if (cmd.publish)
        begin
            out_reg.new_pos_x     <= npos_arr[0];
            out_reg.new_pos_y     <= npos_arr[1];
            out_reg.new_pos_z     <= npos_arr[2];
            out_reg.new_vel_x     <= nvel_arr[0];
            out_reg.new_vel_y     <= nvel_arr[1];
            out_reg.new_vel_z     <= nvel_arr[2];
            out_reg.kinetic_total <= last_reg ? half_sum[KIN_W:1] : '0;
            out_reg.step_done     <= last_reg;
        end
    end

    assign out_item = out_reg;

    a_ksum_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.publish && last_reg && !cmd.kin_add) |=> (ksum_reg == '0))
        else $error("kinetic sum not cleared after last atom");

endmodule

@@ hw/rtl/vauk_ctrl.sv @@
// ----------------------------------------------------------------------------
// vauk_ctrl
// Controller: accepts an atom, runs the lane microprogram, folds the three
// kinetic terms into the sum and loads the result register.
// ----------------------------------------------------------------------------
module vauk_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output vauk_pkg::dp_cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CALC = 4'b0010,
        ST_KIN  = 4'b0100,
        ST_PUB  = 4'b1000
    } state_t;

    state_t                                  state_reg;
    state_t                                  state_next;
    logic [vauk_pkg::STEP_W-1:0]             step_reg;
    logic [vauk_pkg::STEP_W-1:0]             step_next;
    logic [vauk_pkg::LANE_IDX_W-1:0]         kin_reg;
    logic [vauk_pkg::LANE_IDX_W-1:0]         kin_next;
    logic                                    out_valid_reg;
    logic                                    out_valid_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        kin_next    = kin_reg;
        cmd.load    = 1'b0;
        cmd.lane    = vauk_pkg::lane_nop();
        cmd.kin_add = 1'b0;
        cmd.kin_lane = kin_reg;
        cmd.publish = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    step_next  = '0;
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                cmd.lane = vauk_pkg::micro_cmd(step_reg);
                if (step_reg == vauk_pkg::LAST_STEP)
                begin
                    kin_next   = '0;
                    state_next = ST_KIN;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_KIN:
            begin
                cmd.kin_add = 1'b1;
                if (kin_reg == vauk_pkg::LAST_LANE)
                    state_next = ST_PUB;
                else
                    kin_next = kin_reg + 1'b1;
            end
            ST_PUB:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.publish)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            kin_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            kin_reg       <= kin_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_CALC && step_reg == '0))
        else $error("transfer in did not start the microprogram");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CALC) |-> (step_reg <= vauk_pkg::LAST_STEP))
        else $error("microprogram step out of range");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten before transfer");

    a_valid_from_pub: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_PUB))
        else $error("result valid raised outside publish");

endmodule
